/* sv/rec_pkg.sv */
package rec_pkg;

    localparam int KEY_W  = 16;
    localparam int SLOT_W = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ACQ  = 2'd0,
        OP_DUP  = 2'd1,
        OP_REL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic one_rd;
        logic eval;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_acq;
        logic in_direct;
        logic scan_left;
        logic match;
        logic last_eval;
        logic out_busy;
    } sts_t;

endpackage

/* sv/rec_ctrl.sv */
module rec_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rec_pkg::sts_t sts,
    output rec_pkg::cmd_t cmd
);

    rec_pkg::state_t state_reg;
    rec_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rec_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rec_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.in_acq)
                    begin
                        state_next = rec_pkg::S_SCAN;
                    end
                    else if (sts.in_direct)
                    begin
                        state_next = rec_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = rec_pkg::S_FETCH;
                    end
                end
            end
            rec_pkg::S_SCAN:
            begin
                if (sts.match || sts.last_eval)
                begin
                    state_next = rec_pkg::S_DONE;
                end
            end
            rec_pkg::S_FETCH:
            begin
                state_next = rec_pkg::S_DONE;
            end
            rec_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = rec_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rec_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            rec_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rec_pkg::S_SCAN:
            begin
                cmd.eval    = 1'b1;
                cmd.scan_rd = sts.scan_left && !sts.match;
            end
            rec_pkg::S_FETCH:
            begin
                cmd.one_rd = 1'b1;
            end
            rec_pkg::S_DONE:
            begin
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* sv/rec_datapath.sv */
module rec_datapath #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rec_pkg::cmd_t               cmd,
    output rec_pkg::sts_t               sts,
    input  logic [rec_pkg::OP_W-1:0]    op,
    input  logic [rec_pkg::KEY_W-1:0]   key,
    input  logic [rec_pkg::SLOT_W-1:0]  slot_in,
    input  logic                        links_zero,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rec_pkg::SLOT_W-1:0]  slot_out,
    output logic                        hit,
    output logic                        fresh,
    output logic                        destroy,
    output logic [rec_pkg::ST_W-1:0]    status
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SLOT_W = rec_pkg::SLOT_W;
    localparam int KEY_W  = rec_pkg::KEY_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(ENTRIES);

    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
    logic [KEY_W-1:0]      key_mem [ENTRIES];
    logic [ENTRIES-1:0]    vld_reg;

    rec_pkg::op_t       op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               lz_reg;

    logic [IDX_W:0]          scan_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [KEY_W-1:0]        rd_key_reg;
    logic [COUNT_BITS-1:0]   rd_cnt_reg;
    logic                    rd_vld_reg;
    logic                    hit_reg;
    logic                    free_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       slot_out_reg;
    logic                    hit_out_reg;
    logic                    fresh_reg;
    logic                    destroy_reg;
    rec_pkg::status_t        status_reg;

    logic [COUNT_BITS-1:0]     cur_cnt;
    logic                      match;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W+SLOT_W-1:0]   slot_ext;
    logic [IDX_W-1:0]          slot_idx;
    logic [IDX_W+SLOT_W-1:0]   rd_ext;
    logic [IDX_W+SLOT_W-1:0]   free_ext;
    logic                      slot_oob;

    logic                      cnt_we;
    logic                      key_we;
    logic [IDX_W-1:0]          wr_idx;
    logic [COUNT_BITS-1:0]     wr_cnt;
    logic [SLOT_W-1:0]         res_slot;
    logic                      res_hit;
    logic                      res_fresh;
    logic                      res_destroy;
    rec_pkg::status_t          res_status;

    assign cur_cnt  = rd_vld_reg ? rd_cnt_reg : '0;
    assign match    = rd_pend_reg && (cur_cnt != '0) && (rd_key_reg == key_reg);
    assign slot_ext = {{IDX_W{1'b0}}, slot_reg};
    assign slot_idx = slot_ext[IDX_W-1:0];
    assign rd_ext   = {{SLOT_W{1'b0}}, rd_idx_reg};
    assign free_ext = {{SLOT_W{1'b0}}, free_idx_reg};
    assign slot_oob = 32'(slot_reg) >= ENTRIES;
    assign rd_en    = cmd.scan_rd || cmd.one_rd;
    assign rd_addr  = cmd.one_rd ? slot_idx : scan_reg[IDX_W-1:0];

    assign sts.in_acq    = rec_pkg::op_t'(op) == rec_pkg::OP_ACQ;
    assign sts.in_direct = (rec_pkg::op_t'(op) == rec_pkg::OP_NONE)
                           || (32'(slot_in) >= ENTRIES);
    assign sts.scan_left = scan_reg < SCAN_END;
    assign sts.match     = match;
    assign sts.last_eval = rd_pend_reg && (rd_idx_reg == IDX_LAST);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= rec_pkg::op_t'(op);
            key_reg  <= key;
            slot_reg <= slot_in;
            lz_reg   <= links_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (cmd.load)
            begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cmd.eval && match)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmd.eval && rd_pend_reg && (cur_cnt == '0) && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && rd_pend_reg && (cur_cnt == '0) && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    always_comb
    begin
        cnt_we      = 1'b0;
        key_we      = 1'b0;
        wr_idx      = rd_idx_reg;
        wr_cnt      = cur_cnt;
        res_slot    = '0;
        res_hit     = 1'b0;
        res_fresh   = 1'b0;
        res_destroy = 1'b0;
        res_status  = rec_pkg::ST_OK;
        case (op_reg)
            rec_pkg::OP_ACQ:
            begin
                if (hit_reg)
                begin
                    res_slot = rd_ext[SLOT_W-1:0];
                    res_hit  = 1'b1;
                    if (cur_cnt == CNT_MAX)
                    begin
                        res_status = rec_pkg::ST_OVER;
                    end
                    else
                    begin
                        cnt_we = 1'b1;
                        wr_cnt = cur_cnt + CNT_ONE;
                    end
                end
                else if (free_reg)
                begin
                    wr_idx    = free_idx_reg;
                    wr_cnt    = CNT_ONE;
                    cnt_we    = 1'b1;
                    key_we    = 1'b1;
                    res_slot  = free_ext[SLOT_W-1:0];
                    res_fresh = 1'b1;
                end
                else
                begin
                    res_status = rec_pkg::ST_FULL;
                end
            end
            rec_pkg::OP_DUP:
            begin
                res_slot = slot_reg;
                if (!slot_oob)
                begin
                    if (cur_cnt == CNT_MAX)
                    begin
                        res_status = rec_pkg::ST_OVER;
                    end
                    else
                    begin
                        cnt_we = 1'b1;
                        wr_cnt = cur_cnt + CNT_ONE;
                    end
                end
            end
            rec_pkg::OP_REL:
            begin
                res_slot = slot_reg;
                if (!slot_oob)
                begin
                    if (cur_cnt == '0)
                    begin
                        res_status = rec_pkg::ST_UNDER;
                    end
                    else
                    begin
                        cnt_we      = 1'b1;
                        wr_cnt      = cur_cnt - CNT_ONE;
                        res_destroy = (cur_cnt == CNT_ONE) && lz_reg;
                    end
                end
            end
            default:
            begin
                res_slot = '0;
            end
        endcase
        cnt_we = cnt_we && cmd.commit;
        key_we = key_we && cmd.commit;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
        if (key_we)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (rd_en)
        begin
            rd_cnt_reg <= cnt_mem[rd_addr];
            rd_key_reg <= key_mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cnt_we)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_out_reg <= res_slot;
            hit_out_reg  <= res_hit;
            fresh_reg    <= res_fresh;
            destroy_reg  <= res_destroy;
            status_reg   <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign hit       = hit_out_reg;
    assign fresh     = fresh_reg;
    assign destroy   = destroy_reg;
    assign status    = status_reg;

    a_one_read_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_rd && cmd.one_rd))
        else $error("scan read and slot read issued together");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result committed over a pending result");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_we || key_we) |-> !rd_en)
        else $error("slot write during a slot read");

endmodule

/* sv/refcounted_entry_cache.sv */
// Reference-counted slot cache. One request at a time: acquire scans the slot
// table through the single read port of the slot memory, one slot per cycle,
// and stops early when the key hits; duplicate and release read one slot; an
// unused op or an out-of-range slot reads none. Counts come out of reset as
// zero through per-slot valid bits, so no clearing pass is needed. A finished
// result waits in the output register while the next request is accepted.
module refcounted_entry_cache #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rec_pkg::OP_W-1:0]    op,
    input  logic [rec_pkg::KEY_W-1:0]   key,
    input  logic [rec_pkg::SLOT_W-1:0]  slot_in,
    input  logic                        links_zero,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rec_pkg::SLOT_W-1:0]  slot_out,
    output logic                        hit,
    output logic                        fresh,
    output logic                        destroy,
    output logic [rec_pkg::ST_W-1:0]    status
);

    rec_pkg::cmd_t cmd;
    rec_pkg::sts_t sts;

    rec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rec_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .key        (key),
        .slot_in    (slot_in),
        .links_zero (links_zero),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_out   (slot_out),
        .hit        (hit),
        .fresh      (fresh),
        .destroy    (destroy),
        .status     (status)
    );

endmodule
